### rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int CAL_IDX_W = 3;

    typedef enum logic [CAL_IDX_W-1:0] {
        CAL_AC1_AC2 = 3'd0,
        CAL_AC3_AC4 = 3'd1,
        CAL_AC5_AC6 = 3'd2,
        CAL_B1_B2   = 3'd3,
        CAL_MC_MD   = 3'd4
    } t_cal_idx;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
    } t_cal;

    localparam logic [11:0] B6_OFS    = 12'd4000;
    localparam logic [15:0] B4_OFS    = 16'd32768;
    localparam logic [15:0] B7_MUL    = 16'd50000;
    localparam logic [11:0] P_C1      = 12'd3038;
    localparam logic [12:0] P_C2      = 13'd7357;
    localparam logic [11:0] P_C3      = 12'd3791;
    localparam int          T_MIN     = -4096;
    localparam int          T_MAX     = 4095;
    localparam logic [17:0] PRESS_MAX = 18'h3FFFF;

    // sideband through the temperature divider
    typedef struct packed {
        logic signed [18:0] x1t;
        logic [15:0]        up;
        logic               neg;
        logic               zero;
    } t_tdiv_side;

    typedef struct packed {
        logic signed [12:0] t;
        logic signed [28:0] b6;
        logic [15:0]        up;
        logic               err;
    } t_temp_out;

    typedef struct packed {
        logic signed [12:0] t;
        logic [15:0]        up;
        logic               err;
    } t_carry;

    typedef struct packed {
        logic [16:0]        b4;
        logic [31:0]        b7;
        logic signed [12:0] t;
        logic               err;
    } t_coef_out;

    // sideband through the pressure divider
    typedef struct packed {
        logic signed [12:0] t;
        logic               err;
        logic               zero;
        logic               hi;
    } t_pdiv_side;

    typedef struct packed {
        logic signed [12:0] t;
        logic               err;
        logic               zero;
        logic               sat;
        logic [17:0]        p;
    } t_pcarry;

endpackage

### rtl/core/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one raw temperature and one raw
// pressure word; a transfer happens when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry temperature in 0.1 degC,
// pressure in Pa and a flag for a zero divisor.
// Calibration is loaded through i_cfg_we / i_cfg_idx / i_cfg_wdata, one
// 32-bit word per register index; the user must load it while no transfer is
// in flight, since the block does not enforce this. Two pipelined dividers
// (27 and 32 stages) and the multiply stages lie between the input transfer
// and o_out_valid. Throughput is one transfer per cycle while not stalled.
// Reset clears the calibration words and every stage valid bit.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_in_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CAL_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [15:0]          i_raw_temp,
    input  logic [15:0]          i_raw_press,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [12:0]   o_temp_tenths,
    output logic [17:0]          o_press_pa,
    output logic                 o_div_error
);

    logic [31:0] r_cal_ac1_ac2;
    logic [31:0] r_cal_ac3_ac4;
    logic [31:0] r_cal_ac5_ac6;
    logic [31:0] r_cal_b1_b2;
    logic [31:0] r_cal_mc_md;
    t_cal        w_cal;
    logic        w_en;
    logic        w_temp_vld;
    t_temp_out   w_temp;
    logic        w_coef_vld;
    t_coef_out   w_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_ac1_ac2 <= '0;
            r_cal_ac3_ac4 <= '0;
            r_cal_ac5_ac6 <= '0;
            r_cal_b1_b2   <= '0;
            r_cal_mc_md   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cal_idx'(i_cfg_idx))
                CAL_AC1_AC2: r_cal_ac1_ac2 <= i_cfg_wdata;
                CAL_AC3_AC4: r_cal_ac3_ac4 <= i_cfg_wdata;
                CAL_AC5_AC6: r_cal_ac5_ac6 <= i_cfg_wdata;
                CAL_B1_B2:   r_cal_b1_b2   <= i_cfg_wdata;
                CAL_MC_MD:   r_cal_mc_md   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_cal.ac1 = signed'(r_cal_ac1_ac2[31:16]);
    assign w_cal.ac2 = signed'(r_cal_ac1_ac2[15:0]);
    assign w_cal.ac3 = signed'(r_cal_ac3_ac4[31:16]);
    assign w_cal.ac4 = r_cal_ac3_ac4[15:0];
    assign w_cal.ac5 = r_cal_ac5_ac6[31:16];
    assign w_cal.ac6 = r_cal_ac5_ac6[15:0];
    assign w_cal.b1  = signed'(r_cal_b1_b2[31:16]);
    assign w_cal.b2  = signed'(r_cal_b1_b2[15:0]);
    assign w_cal.mc  = signed'(r_cal_mc_md[31:16]);
    assign w_cal.md  = signed'(r_cal_mc_md[15:0]);

    // pipeline holds while a result waits on a stalled receiver
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    bsc_temp u_temp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_cal       (w_cal),
        .i_valid     (i_in_valid),
        .i_raw_temp  (i_raw_temp),
        .i_raw_press (i_raw_press),
        .o_valid     (w_temp_vld),
        .o_data      (w_temp)
    );

    bsc_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cal   (w_cal),
        .i_valid (w_temp_vld),
        .i_data  (w_temp),
        .o_valid (w_coef_vld),
        .o_data  (w_coef)
    );

    bsc_press u_press (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_coef_vld),
        .i_data        (w_coef),
        .o_valid       (o_out_valid),
        .o_temp_tenths (o_temp_tenths),
        .o_press_pa    (o_press_pa),
        .o_div_error   (o_div_error)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(w_temp_vld) && $stable(w_coef_vld))
        else $error("pipeline moved while held");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CAL_MC_MD) |=> r_cal_mc_md == $past(i_cfg_wdata))
        else $error("calibration write lost");

endmodule

### rtl/core/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module bsc_div #(
    parameter int W_NUM  = 32,
    parameter int W_DEN  = 17,
    parameter int W_SIDE = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W_NUM-1:0]  i_num,
    input  logic [W_DEN-1:0]  i_den,
    input  logic [W_SIDE-1:0] i_side,
    output logic              o_valid,
    output logic [W_NUM-1:0]  o_quo,
    output logic [W_SIDE-1:0] o_side
);

    logic              r_vld  [W_NUM];
    logic [W_DEN-1:0]  r_rem  [W_NUM];
    logic [W_NUM-1:0]  r_dq   [W_NUM];
    logic [W_DEN-1:0]  r_den  [W_NUM];
    logic [W_SIDE-1:0] r_side [W_NUM];

    for (genvar i = 0; i < W_NUM; i++) begin : g_stage
        logic              p_vld;
        logic [W_DEN-1:0]  p_rem;
        logic [W_NUM-1:0]  p_dq;
        logic [W_DEN-1:0]  p_den;
        logic [W_SIDE-1:0] p_side;
        logic [W_DEN:0]    w_trial;
        logic [W_DEN:0]    w_diff;
        logic              w_ge;

        if (i == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_dq   = i_num;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[i-1];
            assign p_rem  = r_rem[i-1];
            assign p_dq   = r_dq[i-1];
            assign p_den  = r_den[i-1];
            assign p_side = r_side[i-1];
        end

        assign w_trial = {p_rem, p_dq[W_NUM-1]};
        assign w_diff  = w_trial - {1'b0, p_den};
        assign w_ge    = !w_diff[W_DEN];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= w_ge ? w_diff[W_DEN-1:0] : w_trial[W_DEN-1:0];
                r_dq[i]   <= {p_dq[W_NUM-2:0], w_ge};
                r_den[i]  <= p_den;
                r_side[i] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[W_NUM-1];
    assign o_quo   = r_dq[W_NUM-1];
    assign o_side  = r_side[W_NUM-1];

endmodule

### rtl/core/bsc_temp.sv
// ----------------------------------------------------------------------------
// bsc_temp
// Temperature path: X1, X2 through a pipelined divider, B5, T and B6.
// ----------------------------------------------------------------------------
module bsc_temp
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_cal        i_cal,
    input  logic        i_valid,
    input  logic [15:0] i_raw_temp,
    input  logic [15:0] i_raw_press,
    output logic        o_valid,
    output t_temp_out   o_data
);

    logic signed [16:0] w_d;
    logic signed [33:0] w_prod;
    logic signed [18:0] w_x1t;
    logic [15:0]        w_mc_mag;
    logic [19:0]        w_den_mag;
    t_tdiv_side         w_side;
    logic               w_dvld;
    logic [26:0]        w_q;
    t_tdiv_side         w_dside;
    logic signed [27:0] w_x2;
    logic signed [28:0] w_tr;
    logic signed [28:0] w_tq;
    t_temp_out          n_s5;

    logic               r_s1_vld;
    logic signed [33:0] r_s1_prod;
    logic [15:0]        r_s1_up;
    logic               r_s2_vld;
    logic signed [18:0] r_s2_x1t;
    logic signed [19:0] r_s2_den;
    logic [15:0]        r_s2_up;
    logic               r_s3_vld;
    logic [26:0]        r_s3_num;
    logic [19:0]        r_s3_den;
    t_tdiv_side         r_s3_side;
    logic               r_s4_vld;
    logic signed [27:0] r_s4_b5;
    logic [15:0]        r_s4_up;
    logic               r_s4_err;
    logic               r_s5_vld;
    t_temp_out          r_s5;

    // x1 product
    assign w_d    = signed'({1'b0, i_raw_temp}) - signed'({1'b0, i_cal.ac6});
    assign w_prod = 34'(w_d) * 34'(signed'({1'b0, i_cal.ac5}));

    // x1 with truncation toward zero
    assign w_x1t = r_s1_prod[33] ? 19'((r_s1_prod + 34'sd32767) >>> 15)
                                 : 19'(r_s1_prod >>> 15);

    // sign and magnitude for the divider
    assign w_mc_mag  = 16'(i_cal.mc[15] ? -17'(i_cal.mc) : 17'(i_cal.mc));
    assign w_den_mag = r_s2_den[19] ? 20'(-r_s2_den) : 20'(r_s2_den);
    assign w_side.x1t  = r_s2_x1t;
    assign w_side.up   = r_s2_up;
    assign w_side.neg  = i_cal.mc[15] ^ r_s2_den[19];
    assign w_side.zero = (r_s2_den == '0);

    bsc_div #(
        .W_NUM  (27),
        .W_DEN  (20),
        .W_SIDE ($bits(t_tdiv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_s3_vld),
        .i_num   (r_s3_num),
        .i_den   (r_s3_den),
        .i_side  (r_s3_side),
        .o_valid (w_dvld),
        .o_quo   (w_q),
        .o_side  (w_dside)
    );

    assign w_x2 = w_dside.zero ? '0
                : (w_dside.neg ? -signed'({1'b0, w_q}) : signed'({1'b0, w_q}));

    // temperature, rounded then truncated toward zero
    assign w_tr = 29'(r_s4_b5) + 29'sd8;
    assign w_tq = w_tr[28] ? ((w_tr + 29'sd15) >>> 4) : (w_tr >>> 4);

    always_comb begin
        n_s5.b6  = 29'(r_s4_b5) - signed'(29'(B6_OFS));
        n_s5.up  = r_s4_up;
        n_s5.err = r_s4_err;
        if (w_tq < T_MIN) begin
            n_s5.t = 13'(T_MIN);
        end else if (w_tq > T_MAX) begin
            n_s5.t = 13'(T_MAX);
        end else begin
            n_s5.t = 13'(w_tq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= w_dvld;
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_prod <= w_prod;
            r_s1_up   <= i_raw_press;
            r_s2_x1t  <= w_x1t;
            r_s2_den  <= 20'(w_x1t) + 20'(i_cal.md);
            r_s2_up   <= r_s1_up;
            r_s3_num  <= {w_mc_mag, 11'b0};
            r_s3_den  <= w_den_mag;
            r_s3_side <= w_side;
            r_s4_b5   <= 28'(w_dside.x1t) + w_x2;
            r_s4_up   <= w_dside.up;
            r_s4_err  <= w_dside.zero;
            r_s5      <= n_s5;
        end
    end

    assign o_valid = r_s5_vld;
    assign o_data  = r_s5;

endmodule

### rtl/core/bsc_coef.sv
// ----------------------------------------------------------------------------
// bsc_coef
// Pressure coefficients: B6 square, B3, B4 and B7 over ten register stages.
// ----------------------------------------------------------------------------
module bsc_coef
    import bsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_cal      i_cal,
    input  logic      i_valid,
    input  t_temp_out i_data,
    output logic      o_valid,
    output t_coef_out o_data
);

    logic [9:0]         r_vld;
    t_carry             r_cy [10];
    t_carry             w_cy_in;

    logic signed [28:0] r_c1_b6;
    logic [27:0]        r_c1_mag;
    logic [27:0]        r_c2_hh;
    logic [27:0]        r_c2_hl;
    logic [27:0]        r_c2_ll;
    logic signed [44:0] r_c2_a2b6;
    logic signed [44:0] r_c2_a3b6;
    logic [43:0]        r_c3_s;
    logic signed [33:0] r_x2p  [3:5];
    logic signed [31:0] r_x1q  [3:5];
    logic signed [38:0] r_c4_b2sh;
    logic signed [38:0] r_c4_b2sl;
    logic signed [38:0] r_c4_b1sh;
    logic signed [38:0] r_c4_b1sl;
    logic signed [48:0] r_c5_x1p;
    logic signed [43:0] r_c5_x2q;
    logic signed [49:0] r_c6_x3;
    logic signed [44:0] r_c6_x3qn;
    logic signed [50:0] r_c7_b3n;
    logic signed [42:0] r_c7_x3q;
    logic [31:0]        r_c8_b3lo;
    logic [31:0]        r_c8_x3qa;
    logic [16:0]        r_c9_b4;
    logic [31:0]        r_c9_diff;
    logic [16:0]        r_c10_b4;
    logic [31:0]        r_c10_b7;

    logic [55:0]        w_sq;
    logic [13:0]        w_h;
    logic [13:0]        w_l;
    logic [21:0]        w_sh;
    logic [21:0]        w_sl;
    logic signed [59:0] w_pb2;
    logic signed [59:0] w_pb1;
    logic signed [50:0] w_b3n;
    logic signed [50:0] w_b3;
    logic signed [42:0] w_x3q;
    logic [31:0]        w_b4p;

    assign w_cy_in.t   = i_data.t;
    assign w_cy_in.up  = i_data.up;
    assign w_cy_in.err = i_data.err;

    assign w_h   = r_c1_mag[27:14];
    assign w_l   = r_c1_mag[13:0];
    assign w_sq  = (56'(r_c2_hh) << 28) + (56'(r_c2_hl) << 15) + 56'(r_c2_ll);
    assign w_sh  = r_c3_s[43:22];
    assign w_sl  = r_c3_s[21:0];
    assign w_pb2 = (60'(r_c4_b2sh) <<< 22) + 60'(r_c4_b2sl);
    assign w_pb1 = (60'(r_c4_b1sh) <<< 22) + 60'(r_c4_b1sl);
    assign w_b3n = (51'(i_cal.ac1) <<< 2) + 51'(r_c6_x3) + 51'sd2;
    assign w_x3q = r_c6_x3qn[44] ? 43'((r_c6_x3qn + 45'sd3) >>> 2)
                                 : 43'(r_c6_x3qn >>> 2);
    assign w_b3  = r_c7_b3n[50] ? ((r_c7_b3n + 51'sd3) >>> 2) : (r_c7_b3n >>> 2);
    assign w_b4p = 32'(i_cal.ac4) * r_c8_x3qa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[8:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cy[0] <= w_cy_in;
            for (int k = 1; k < 10; k++) begin
                r_cy[k] <= r_cy[k-1];
            end

            // stage 1: magnitude of b6
            r_c1_b6  <= i_data.b6;
            r_c1_mag <= 28'(i_data.b6[28] ? -i_data.b6 : i_data.b6);

            // stage 2: partial squares and linear products
            r_c2_hh   <= 28'(w_h) * 28'(w_h);
            r_c2_hl   <= 28'(w_h) * 28'(w_l);
            r_c2_ll   <= 28'(w_l) * 28'(w_l);
            r_c2_a2b6 <= 45'(i_cal.ac2) * 45'(r_c1_b6);
            r_c2_a3b6 <= 45'(i_cal.ac3) * 45'(r_c1_b6);

            // stage 3: b6 squared over 4096
            r_c3_s    <= w_sq[55:12];
            r_x2p[3]  <= 34'(r_c2_a2b6 >>> 11);
            r_x1q[3]  <= 32'(r_c2_a3b6 >>> 13);

            // stage 4: b1 and b2 partial products
            r_c4_b2sh <= 39'(i_cal.b2) * 39'(signed'({1'b0, w_sh}));
            r_c4_b2sl <= 39'(i_cal.b2) * 39'(signed'({1'b0, w_sl}));
            r_c4_b1sh <= 39'(i_cal.b1) * 39'(signed'({1'b0, w_sh}));
            r_c4_b1sl <= 39'(i_cal.b1) * 39'(signed'({1'b0, w_sl}));
            r_x2p[4]  <= r_x2p[3];
            r_x1q[4]  <= r_x1q[3];

            // stage 5
            r_c5_x1p  <= 49'(w_pb2 >>> 11);
            r_c5_x2q  <= 44'(w_pb1 >>> 16);
            r_x2p[5]  <= r_x2p[4];
            r_x1q[5]  <= r_x1q[4];

            // stage 6
            r_c6_x3   <= 50'(r_c5_x1p) + 50'(r_x2p[5]);
            r_c6_x3qn <= 45'(r_x1q[5]) + 45'(r_c5_x2q) + 45'sd2;

            // stage 7
            r_c7_b3n  <= w_b3n;
            r_c7_x3q  <= w_x3q;

            // stage 8
            r_c8_b3lo <= 32'(w_b3);
            r_c8_x3qa <= 32'(r_c7_x3q) + 32'(B4_OFS);

            // stage 9
            r_c9_b4   <= w_b4p[31:15];
            r_c9_diff <= 32'(r_cy[7].up) - r_c8_b3lo;

            // stage 10
            r_c10_b4  <= r_c9_b4;
            r_c10_b7  <= r_c9_diff * 32'(B7_MUL);
        end
    end

    assign o_valid     = r_vld[9];
    assign o_data.b4   = r_c10_b4;
    assign o_data.b7   = r_c10_b7;
    assign o_data.t    = r_cy[9].t;
    assign o_data.err  = r_cy[9].err;

endmodule

### rtl/core/bsc_press.sv
// ----------------------------------------------------------------------------
// bsc_press
// Pressure path: B7 / B4 through a pipelined divider, then the final
// polynomial correction, saturation and the output register.
// ----------------------------------------------------------------------------
module bsc_press
    import bsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_coef_out          i_data,
    output logic               o_valid,
    output logic signed [12:0] o_temp_tenths,
    output logic [17:0]        o_press_pa,
    output logic               o_div_error
);

    logic [31:0]        w_num;
    t_pdiv_side         w_side;
    logic               w_dvld;
    logic [31:0]        w_q;
    t_pdiv_side         w_dside;
    logic [32:0]        w_p33;
    t_pcarry            n_p2;
    logic signed [31:0] w_pv;
    logic signed [18:0] w_sum;
    logic signed [19:0] w_pf;
    logic [17:0]        n_press;

    logic               r_p2_vld;
    t_pcarry            r_p2;
    logic               r_p3_vld;
    t_pcarry            r_p3;
    logic [19:0]        r_p3_sq;
    logic signed [31:0] r_p3_x2m;
    logic               r_p4_vld;
    t_pcarry            r_p4;
    logic [31:0]        r_p4_x1;
    logic signed [31:0] r_p4_x2m;
    logic               r_p5_vld;
    t_pcarry            r_p5;
    logic signed [18:0] r_p5_sum;
    logic               r_out_vld;
    logic signed [12:0] r_out_t;
    logic [17:0]        r_out_p;
    logic               r_out_err;

    // b7 below 2^31 is doubled before the divide, otherwise the quotient is doubled after it
    assign w_num       = i_data.b7[31] ? i_data.b7 : {i_data.b7[30:0], 1'b0};
    assign w_side.t    = i_data.t;
    assign w_side.err  = i_data.err;
    assign w_side.zero = (i_data.b4 == '0);
    assign w_side.hi   = i_data.b7[31];

    bsc_div #(
        .W_NUM  (32),
        .W_DEN  (17),
        .W_SIDE ($bits(t_pdiv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_num   (w_num),
        .i_den   (i_data.b4),
        .i_side  (w_side),
        .o_valid (w_dvld),
        .o_quo   (w_q),
        .o_side  (w_dside)
    );

    assign w_p33     = w_dside.hi ? {w_q, 1'b0} : {1'b0, w_q};
    assign n_p2.t    = w_dside.t;
    assign n_p2.err  = w_dside.err;
    assign n_p2.zero = w_dside.zero;
    // at or above 2^18 the correction is positive, so the result saturates
    assign n_p2.sat  = |w_p33[32:18];
    assign n_p2.p    = w_p33[17:0];

    assign w_pv  = signed'({14'b0, r_p2.p});
    assign w_sum = 19'(r_p4_x1[31:16]) + 19'(r_p4_x2m >>> 16) + 19'(P_C3);
    assign w_pf  = signed'({2'b0, r_p5.p}) + 20'(r_p5_sum >>> 4);

    always_comb begin
        if (r_p5.zero) begin
            n_press = '0;
        end else if (r_p5.sat) begin
            n_press = PRESS_MAX;
        end else if (w_pf < 0) begin
            n_press = '0;
        end else if (w_pf > signed'(20'(PRESS_MAX))) begin
            n_press = PRESS_MAX;
        end else begin
            n_press = w_pf[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_p2_vld  <= w_dvld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_p5_vld  <= r_p4_vld;
            r_out_vld <= r_p5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2      <= n_p2;
            r_p3      <= r_p2;
            r_p3_sq   <= 20'(r_p2.p[17:8]) * 20'(r_p2.p[17:8]);
            r_p3_x2m  <= -(w_pv * 32'(P_C2));
            r_p4      <= r_p3;
            r_p4_x1   <= 32'(r_p3_sq) * 32'(P_C1);
            r_p4_x2m  <= r_p3_x2m;
            r_p5      <= r_p4;
            r_p5_sum  <= w_sum;
            r_out_t   <= r_p5.t;
            r_out_p   <= n_press;
            r_out_err <= r_p5.err | r_p5.zero;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_temp_tenths = r_out_t;
    assign o_press_pa    = r_out_p;
    assign o_div_error   = r_out_err;

endmodule
